// ===== hw/rtl/i2cee_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cee_pkg
// Shared types and constants of the I2C EEPROM slave: item codes, register
// indexes and the request and response bundles of the remainder unit.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cee_pkg;

   localparam int DVD_W = 16;
   localparam int DSR_W = 17;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 9;

   typedef enum logic [2:0] {
      FUNC_START_STOP  = 3'd0,
      FUNC_BUS_WRITE   = 3'd1,
      FUNC_BUS_READ    = 3'd2,
      FUNC_DIRECT_WRITE = 3'd3,
      FUNC_DIRECT_READ = 3'd4
   } func_type;

   localparam logic [CSR_IDX_W-1:0] CSR_DEV_WRITE_ADDR = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEV_READ_ADDR  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PAGE_BYTES     = 2'd2;

   localparam logic [7:0] RST_DEV_WRITE_ADDR = 8'd160;
   localparam logic [7:0] RST_DEV_READ_ADDR  = 8'd161;
   localparam logic [8:0] RST_PAGE_BYTES     = 9'd32;

   typedef struct packed {
      logic             start;
      logic [DVD_W-1:0] dividend;
      logic [DSR_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DVD_W-1:0] remainder;
   } div_rsp_type;

endpackage

`default_nettype wire

// ===== hw/rtl/i2cee_div.sv =====
// ----------------------------------------------------------------------------
// i2cee_div
// Restoring remainder unit: one quotient bit per cycle, a one-cycle done
// pulse with the remainder held afterwards.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cee_div (
   input  wire                 clock,
   input  wire                 reset,
   input  i2cee_pkg::div_req_type req,
   output i2cee_pkg::div_rsp_type rsp
);

   logic                             busy_ff, busy_in;
   logic                             done_ff, done_in;
   logic [3:0]                       cnt_ff, cnt_in;
   logic [i2cee_pkg::DVD_W-1:0]      rem_ff, rem_in;
   logic [i2cee_pkg::DVD_W-1:0]      dvd_ff, dvd_in;
   logic [i2cee_pkg::DSR_W-1:0]      dsr_ff, dsr_in;
   logic [i2cee_pkg::DSR_W-1:0]      trial;

   assign trial = {rem_ff, dvd_ff[i2cee_pkg::DVD_W-1]};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = 4'd0;
         rem_in  = '0;
         dvd_in  = req.dividend;
         dsr_in  = req.divisor;
      end else if (busy_ff) begin
         // The partial remainder stays below the divisor, so it fits 16 bits.
         if (trial >= dsr_ff) begin
            rem_in = i2cee_pkg::DVD_W'(trial - dsr_ff);
         end else begin
            rem_in = trial[i2cee_pkg::DVD_W-1:0];
         end
         dvd_in = {dvd_ff[i2cee_pkg::DVD_W-2:0], 1'b0};
         cnt_in = cnt_ff + 4'd1;
         if (cnt_ff == 4'd15) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 4'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
   end

   assign rsp.done      = done_ff;
   assign rsp.remainder = rem_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/i2cee_mem.sv =====
// ----------------------------------------------------------------------------
// i2cee_mem
// Single-port byte memory of the EEPROM array with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cee_mem #(
   parameter int MEM_BYTES = 4096,
   parameter int ADDR_W    = 12
) (
   input  wire              clock,
   input  wire              en,
   input  wire              we,
   input  wire [ADDR_W-1:0] addr,
   input  wire [7:0]        wdata,
   output logic [7:0]       rdata
);

   logic [7:0] mem_array [0:MEM_BYTES-1];
   logic [7:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_array[addr] <= wdata;
         end else begin
            rdata_ff <= mem_array[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/i2c_eeprom_slave.sv =====
// ----------------------------------------------------------------------------
// i2c_eeprom_slave
// Byte-level I2C serial EEPROM slave with a two-byte memory address and a
// backdoor port into the array.
// ----------------------------------------------------------------------------
// Usage: one transaction on req_ carries a function code in req_tuser and a
// data byte and memory address in req_tdata. Every transaction produces
// exactly one rsp_ transaction: the ack bit in rsp_tuser and the read byte
// in rsp_tdata. Device addresses and page size are written on csr_, which
// is always ready; write them only while the block is idle.
// An item is taken only when the controller is idle; the result sits in an
// output register, so a stalled rsp_ side holds back only the next result.
// Path from the accepting edge to rsp_tvalid high: start/stop, unused codes
// and bytes that only change the transaction state pass S_EXEC and S_DONE;
// direct writes add S_FOLD and direct or bus reads S_FOLD and S_MEM_RD, to
// fold the address into the array with a two-register reciprocal multiply;
// the second address byte adds S_DIV_PAGE, finding the page base with the
// 16-step remainder unit; a stored data byte adds S_FOLD, which writes the
// array and starts the remainder unit, then S_DIV_NEXT for the page rollover.
// req_tready rises with rsp_tvalid, so no item is taken before the last one's
// result is registered; a stall on rsp_ holds the next result in S_DONE.
// Reset: control state and registers return to their defaults, then the
// array is filled with FILL_VALUE, one byte per cycle over all MEM_BYTES
// bytes, with req_tready low meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_eeprom_slave #(
   parameter int MEM_BYTES  = 4096,
   parameter int FILL_VALUE = 255
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [23:0] req_tdata,   // [7:0] data_byte, [23:8] mem_address
   input  wire  [2:0]  req_tuser,   // [2:0] func
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] read_byte
   output logic        rsp_tuser,   // [0] ack_bit
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [i2cee_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire  [i2cee_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int ADDR_W = (MEM_BYTES > 1) ? $clog2(MEM_BYTES) : 1;
   localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(MEM_BYTES - 1);
   // The floor of 2^32 / MEM_BYTES gives a quotient estimate that is exact
   // or one short for any 16-bit address.
   localparam logic [32:0] FOLD_RECIP = 33'((64'd1 << 32) / 64'(MEM_BYTES));
   localparam logic [16:0] FOLD_MOD   = 17'(MEM_BYTES);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_EXEC,
      S_DIV_PAGE,
      S_FOLD,
      S_DIV_NEXT,
      S_MEM_RD,
      S_DONE
   } state_type;

   state_type           state_ff, state_in;
   logic [ADDR_W-1:0]   clr_ff, clr_in;

   logic [7:0]          dev_wr_ff, dev_wr_in;
   logic [7:0]          dev_rd_ff, dev_rd_in;
   logic [8:0]          page_ff, page_in;

   logic                selected_ff, selected_in;
   logic                read_mode_ff, read_mode_in;
   logic [1:0]          addr_seen_ff, addr_seen_in;
   logic [15:0]         cur_addr_ff, cur_addr_in;
   logic [15:0]         page_start_ff, page_start_in;

   i2cee_pkg::func_type func_ff, func_in;
   logic [7:0]          data_ff, data_in;
   logic [15:0]         maddr_ff, maddr_in;

   logic                res_ack_ff, res_ack_in;
   logic [7:0]          res_byte_ff, res_byte_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_ack_ff, rsp_ack_in;
   logic [7:0]          rsp_byte_ff, rsp_byte_in;

   logic [8:0]          page_nz;
   logic [15:0]         low_addr;

   logic                fold_start;
   logic [15:0]         fold_src;
   logic [48:0]         fold_prod;
   logic [32:0]         fold_qd;
   logic [32:0]         fold_diff;
   logic [17:0]         fold_fix;
   logic [ADDR_W-1:0]   fold_idx;
   logic [15:0]         fold_a_ff, fold_a_in;
   logic [15:0]         fold_q_ff, fold_q_in;
   logic [17:0]         fold_rem_ff, fold_rem_in;
   logic                fold_v1_ff, fold_v1_in;
   logic                fold_v2_ff, fold_v2_in;

   i2cee_pkg::div_req_type div_req;
   i2cee_pkg::div_rsp_type div_rsp;

   logic                mem_en;
   logic                mem_we;
   logic [ADDR_W-1:0]   mem_addr;
   logic [7:0]          mem_wdata;
   logic [7:0]          mem_rdata;

   i2cee_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   i2cee_mem #(
      .MEM_BYTES (MEM_BYTES),
      .ADDR_W    (ADDR_W)
   ) u_mem (
      .clock (clock),
      .en    (mem_en),
      .we    (mem_we),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   // A page size of zero behaves as a single-byte page.
   assign page_nz  = (page_ff == 9'd0) ? 9'd1 : page_ff;
   // Bus reads may have moved the address since the high byte, so the low
   // byte is merged in rather than substituted.
   assign low_addr = cur_addr_ff | {8'd0, data_ff};

   // Array index: the remainder of the address by MEM_BYTES, from a quotient
   // estimate in fold_q_ff and one conditional subtract on fold_rem_ff.
   assign fold_prod   = {33'd0, fold_src} * {16'd0, FOLD_RECIP};
   assign fold_a_in   = fold_src;
   assign fold_q_in   = fold_prod[47:32];
   assign fold_v1_in  = fold_start;
   assign fold_qd     = {17'd0, fold_q_ff} * {16'd0, FOLD_MOD};
   assign fold_diff   = {17'd0, fold_a_ff} - fold_qd;
   assign fold_rem_in = fold_diff[17:0];
   assign fold_v2_in  = fold_v1_ff;
   assign fold_fix    = (fold_rem_ff >= {1'b0, FOLD_MOD}) ?
                        (fold_rem_ff - {1'b0, FOLD_MOD}) : fold_rem_ff;
   assign fold_idx    = fold_fix[ADDR_W-1:0];

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_byte_ff;
   assign rsp_tuser  = rsp_ack_ff;

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      dev_wr_in     = dev_wr_ff;
      dev_rd_in     = dev_rd_ff;
      page_in       = page_ff;
      selected_in   = selected_ff;
      read_mode_in  = read_mode_ff;
      addr_seen_in  = addr_seen_ff;
      cur_addr_in   = cur_addr_ff;
      page_start_in = page_start_ff;
      func_in       = func_ff;
      data_in       = data_ff;
      maddr_in      = maddr_ff;
      res_ack_in    = res_ack_ff;
      res_byte_in   = res_byte_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_ack_in    = rsp_ack_ff;
      rsp_byte_in   = rsp_byte_ff;

      div_req.start    = 1'b0;
      div_req.dividend = cur_addr_ff;
      div_req.divisor  = {8'd0, page_nz};

      fold_start = 1'b0;
      fold_src   = cur_addr_ff;

      mem_en    = 1'b0;
      mem_we    = 1'b0;
      mem_addr  = fold_idx;
      mem_wdata = data_ff;

      if (csr_valid) begin
         case (csr_index)
            i2cee_pkg::CSR_DEV_WRITE_ADDR: dev_wr_in = csr_wdata[7:0];
            i2cee_pkg::CSR_DEV_READ_ADDR:  dev_rd_in = csr_wdata[7:0];
            i2cee_pkg::CSR_PAGE_BYTES:     page_in   = csr_wdata;
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_CLEAR: begin
            mem_en    = 1'b1;
            mem_we    = 1'b1;
            mem_addr  = clr_ff;
            mem_wdata = 8'(FILL_VALUE);
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == LAST_IDX) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            if (req_tvalid) begin
               func_in  = i2cee_pkg::func_type'(req_tuser);
               data_in  = req_tdata[7:0];
               maddr_in = req_tdata[23:8];
               state_in = S_EXEC;
            end
         end

         S_EXEC: begin
            res_ack_in  = 1'b0;
            res_byte_in = 8'd0;
            state_in    = S_DONE;
            case (func_ff)
               i2cee_pkg::FUNC_START_STOP: begin
                  selected_in  = 1'b0;
                  read_mode_in = 1'b0;
                  addr_seen_in = 2'd0;
               end
               i2cee_pkg::FUNC_BUS_WRITE: begin
                  if (!selected_ff) begin
                     if (data_ff != dev_wr_ff && data_ff != dev_rd_ff) begin
                        res_ack_in = 1'b1;
                     end else begin
                        selected_in  = 1'b1;
                        read_mode_in = (data_ff == dev_rd_ff);
                        addr_seen_in = 2'd0;
                     end
                  end else if (read_mode_ff) begin
                     // Data written while in read mode is dropped.
                  end else if (addr_seen_ff == 2'd0) begin
                     cur_addr_in  = {data_ff, 8'd0};
                     addr_seen_in = 2'd1;
                  end else if (addr_seen_ff == 2'd1) begin
                     cur_addr_in      = low_addr;
                     addr_seen_in     = 2'd2;
                     div_req.start    = 1'b1;
                     div_req.dividend = low_addr;
                     div_req.divisor  = {8'd0, page_nz};
                     state_in         = S_DIV_PAGE;
                  end else begin
                     fold_start = 1'b1;
                     state_in   = S_FOLD;
                  end
               end
               i2cee_pkg::FUNC_BUS_READ: begin
                  fold_start = 1'b1;
                  state_in   = S_FOLD;
               end
               i2cee_pkg::FUNC_DIRECT_WRITE,
               i2cee_pkg::FUNC_DIRECT_READ: begin
                  fold_start = 1'b1;
                  fold_src   = maddr_ff;
                  state_in   = S_FOLD;
               end
               default: ;
            endcase
         end

         S_DIV_PAGE: begin
            if (div_rsp.done) begin
               page_start_in = cur_addr_ff - div_rsp.remainder;
               state_in      = S_DONE;
            end
         end

         S_FOLD: begin
            if (fold_v2_ff) begin
               mem_en = 1'b1;
               case (func_ff)
                  i2cee_pkg::FUNC_BUS_WRITE: begin
                     mem_we           = 1'b1;
                     div_req.start    = 1'b1;
                     div_req.dividend = cur_addr_ff + 16'd1 - page_start_ff;
                     div_req.divisor  = {8'd0, page_nz};
                     state_in         = S_DIV_NEXT;
                  end
                  i2cee_pkg::FUNC_BUS_READ: begin
                     cur_addr_in = cur_addr_ff + 16'd1;
                     state_in    = S_MEM_RD;
                  end
                  i2cee_pkg::FUNC_DIRECT_WRITE: begin
                     mem_we   = 1'b1;
                     state_in = S_DONE;
                  end
                  default: begin
                     state_in = S_MEM_RD;
                  end
               endcase
            end
         end

         S_DIV_NEXT: begin
            if (div_rsp.done) begin
               cur_addr_in = page_start_ff + div_rsp.remainder;
               state_in    = S_DONE;
            end
         end

         S_MEM_RD: begin
            res_byte_in = mem_rdata;
            state_in    = S_DONE;
         end

         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_ack_in   = res_ack_ff;
               rsp_byte_in  = res_byte_ff;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_ff        <= '0;
         dev_wr_ff     <= i2cee_pkg::RST_DEV_WRITE_ADDR;
         dev_rd_ff     <= i2cee_pkg::RST_DEV_READ_ADDR;
         page_ff       <= i2cee_pkg::RST_PAGE_BYTES;
         selected_ff   <= 1'b0;
         read_mode_ff  <= 1'b0;
         addr_seen_ff  <= 2'd0;
         cur_addr_ff   <= 16'd0;
         page_start_ff <= 16'd0;
         rsp_valid_ff  <= 1'b0;
         fold_v1_ff    <= 1'b0;
         fold_v2_ff    <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         dev_wr_ff     <= dev_wr_in;
         dev_rd_ff     <= dev_rd_in;
         page_ff       <= page_in;
         selected_ff   <= selected_in;
         read_mode_ff  <= read_mode_in;
         addr_seen_ff  <= addr_seen_in;
         cur_addr_ff   <= cur_addr_in;
         page_start_ff <= page_start_in;
         rsp_valid_ff  <= rsp_valid_in;
         fold_v1_ff    <= fold_v1_in;
         fold_v2_ff    <= fold_v2_in;
      end
      func_ff     <= func_in;
      data_ff     <= data_in;
      maddr_ff    <= maddr_in;
      res_ack_ff  <= res_ack_in;
      res_byte_ff <= res_byte_in;
      rsp_ack_ff  <= rsp_ack_in;
      rsp_byte_ff <= rsp_byte_in;
      fold_a_ff   <= fold_a_in;
      fold_q_ff   <= fold_q_in;
      fold_rem_ff <= fold_rem_in;
   end

endmodule

`default_nettype wire
